[src/hsc_pkg.sv]
// shared types and constants for the hsv/hsl to rgb converter
package hsc_pkg;

  typedef enum logic {
    MODEL_HSV = 1'b0,
    MODEL_HSL = 1'b1
  } color_model_e;

  // hue circle split into six sectors
  localparam int unsigned HUE_SECTORS = 6;

  // per-channel trapeze offset in sectors
  localparam int unsigned OFFS_RED   = 2;
  localparam int unsigned OFFS_GREEN = 0;
  localparam int unsigned OFFS_BLUE  = 4;

endpackage

[src/hsc_front.sv]
// input clamp, hsl chroma and hexcone value stages
module hsc_front #(
  parameter int unsigned FRAC_BITS = 12,
  parameter int unsigned HUE_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [HUE_BITS-1:0]    hue_i,
  input  logic [FRAC_BITS:0]     sat_i,
  input  logic [FRAC_BITS:0]     level_i,
  output logic                   valid_o,
  output logic [HUE_BITS+2:0]    hue6_o,
  output logic [FRAC_BITS:0]     sat_o,
  output logic [FRAC_BITS:0]     level_o,
  output logic [FRAC_BITS:0]     chroma_o,
  output logic [FRAC_BITS+1:0]   val_o
);
  import hsc_pkg::*;

  localparam int unsigned F = FRAC_BITS;
  localparam int unsigned H = HUE_BITS;
  localparam logic [F:0]   ONE  = {1'b1, {F{1'b0}}};
  localparam logic [F+1:0] ONE2 = {2'b01, {F{1'b0}}};

  logic [2:0]       vld_q;
  logic [H-1:0]     hue1_q;
  logic [F:0]       sat1_q, lvl1_q;
  logic [H+2:0]     hue2_q, hue3_q;
  logic [F:0]       sat2_q, lvl2_q, c2_q, sat3_q, lvl3_q, c3_q;
  logic [F+1:0]     v3_q;

  logic [F:0]       sat_c, lvl_c;
  logic [F+1:0]     twice, lvl_dev, compl_v;
  logic [2*F+1:0]   prod;
  logic [F+1:0]     v_d;

  assign sat_c   = (sat_i > ONE) ? ONE : sat_i;
  assign lvl_c   = (level_i > ONE) ? ONE : level_i;
  assign twice   = {lvl1_q, 1'b0};
  assign lvl_dev = (twice >= ONE2) ? (twice - ONE2) : (ONE2 - twice);
  assign compl_v = ONE2 - lvl_dev;
  assign prod    = compl_v[F:0] * sat1_q;
  assign v_d     = (F+2)'(c2_q >> 1) + (F+2)'(lvl2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue1_q <= hue_i;
      sat1_q <= sat_c;
      lvl1_q <= lvl_c;
      hue2_q <= (H+3)'(hue1_q) * (H+3)'(HUE_SECTORS);
      sat2_q <= sat1_q;
      lvl2_q <= lvl1_q;
      c2_q   <= prod[2*F:F];
      hue3_q <= hue2_q;
      sat3_q <= sat2_q;
      lvl3_q <= lvl2_q;
      c3_q   <= c2_q;
      v3_q   <= v_d;
    end
  end

  assign valid_o  = vld_q[2];
  assign hue6_o   = hue3_q;
  assign sat_o    = sat3_q;
  assign level_o  = lvl3_q;
  assign chroma_o = c3_q;
  assign val_o    = v3_q;

endmodule

[src/hsc_div.sv]
// pipelined restoring divider, one quotient bit per stage, for c*ONE/v
module hsc_div #(
  parameter int unsigned FRAC_BITS = 12,
  parameter int unsigned SIDE_W    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [FRAC_BITS:0]   num_i,
  input  logic [FRAC_BITS+1:0] den_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [FRAC_BITS:0]   quot_o,
  output logic [FRAC_BITS+1:0] den_o,
  output logic [SIDE_W-1:0]    side_o
);
  import hsc_pkg::*;

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned RW = F + 3;

  logic               vld_q  [0:F];
  logic [RW-1:0]      rem_q  [0:F];
  logic [F:0]         quo_q  [0:F];
  logic [F+1:0]       den_q  [0:F];
  logic [SIDE_W-1:0]  side_q [0:F];

  for (genvar k = 0; k <= F; k++) begin : g_stage
    logic              vld_in;
    logic [RW-1:0]     rem_in, rem_sub, rem_nx;
    logic [F:0]        quo_in;
    logic [F+1:0]      den_in;
    logic [SIDE_W-1:0] side_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = RW'(num_i);
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // with a nonzero divisor the remainder stays below twice the divisor, so the shift never drops bits
    assign ge      = rem_in >= RW'(den_in);
    assign rem_sub = ge ? (rem_in - RW'(den_in)) : rem_in;
    assign rem_nx  = {rem_sub[RW-2:0], 1'b0};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_nx;
        quo_q[k]  <= {quo_in[F-1:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[F];
  assign quot_o  = quo_q[F];
  assign den_o   = den_q[F];
  assign side_o  = side_q[F];

endmodule

[src/hsc_chan.sv]
// one output channel: trapeze on the sector position, then v*((1-s)+s*t)
module hsc_chan #(
  parameter int unsigned FRAC_BITS = 12,
  parameter int unsigned HUE_BITS  = 16,
  parameter int unsigned OFFSET    = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [HUE_BITS+2:0]  hue6_i,
  input  logic [FRAC_BITS:0]   sat_i,
  input  logic [FRAC_BITS:0]   level_i,
  output logic [FRAC_BITS:0]   chan_o
);
  import hsc_pkg::*;

  localparam int unsigned F = FRAC_BITS;
  localparam int unsigned H = HUE_BITS;
  localparam int unsigned PW = H + 4;
  localparam logic [PW-1:0] H1   = PW'(1) << H;
  localparam logic [PW-1:0] H3   = PW'(3) << H;
  localparam logic [PW-1:0] SPAN = PW'(HUE_SECTORS) << H;
  localparam logic [PW-1:0] OFFS = PW'(OFFSET) << H;
  localparam logic [F:0]    ONE  = {1'b1, {F{1'b0}}};

  logic [PW-1:0]      p0, p, rise, fall, fall_raw;
  logic [H:0]         t;
  logic [H+F:0]       t_sh;
  logic [F:0]         tq_q, sat_a_q, lvl_a_q, sat_b_q, lvl_b_q;
  logic [2*F+1:0]     prod_d, prod_q;
  logic [F+1:0]       inner;
  logic [2*F+2:0]     outp;
  logic [F:0]         out_q;

  assign p0       = PW'(hue6_i) + OFFS;
  assign p        = (p0 >= SPAN) ? (p0 - SPAN) : p0;
  assign rise     = (p < H1) ? p : H1;
  assign fall_raw = p - H3;
  assign fall     = (p > H3) ? ((fall_raw > H1) ? H1 : fall_raw) : '0;
  assign t        = (H+1)'(rise - fall);
  assign t_sh     = ((H+F+1)'(t) << F) >> H;

  assign prod_d = sat_a_q * tq_q;
  assign inner  = (F+2)'(ONE - sat_b_q) + (F+2)'(prod_q >> F);
  assign outp   = lvl_b_q * inner;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tq_q    <= t_sh[F:0];
      sat_a_q <= sat_i;
      lvl_a_q <= level_i;
      prod_q  <= prod_d;
      sat_b_q <= sat_a_q;
      lvl_b_q <= lvl_a_q;
      out_q   <= outp[2*F:F];
    end
  end

  assign chan_o = out_q;

endmodule

[src/hsv_hsl_to_rgb_converter_unit.sv]
// top level of the hsv/hsl to rgb pixel converter
//
// Input channel in_valid_i/in_ready_o carries one pixel per transaction:
// hue_turn_i (fraction of a turn), sat_in_i and level_in_i (Q1.FRAC_BITS,
// values above one are clamped). Output channel out_valid_o/out_ready_i
// carries red/green/blue in Q1.FRAC_BITS.
// cfg_valid_i/cfg_ready_o writes color_model (0 hsv, 1 hsl); write it only
// while no pixel is in flight. It is always ready.
// Pipeline: 3 front stages, FRAC_BITS+1 divider stages, 1 select stage and
// 3 channel stages lie between input transaction and output valid. The hsl
// saturation divider, one quotient bit per stage, sets the depth.
// Throughput: one pixel per cycle. All stages advance together; when the
// receiver stalls with a result waiting, the whole pipeline holds and
// in_ready_o goes low, so nothing is dropped or repeated.
// Reset clears every valid bit and sets color_model to hsv.
module hsv_hsl_to_rgb_converter_unit #(
  parameter int unsigned FRAC_BITS = 12,
  parameter int unsigned HUE_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [HUE_BITS-1:0]  hue_turn_i,
  input  logic [FRAC_BITS:0]   sat_in_i,
  input  logic [FRAC_BITS:0]   level_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FRAC_BITS:0]   red_out_o,
  output logic [FRAC_BITS:0]   green_out_o,
  output logic [FRAC_BITS:0]   blue_out_o
);
  import hsc_pkg::*;

  localparam int unsigned F = FRAC_BITS;
  localparam int unsigned H = HUE_BITS;
  localparam int unsigned SIDE_W = 1 + (H + 3) + 2 * (F + 1);
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  color_model_e     model_q;
  logic             en;

  logic             fr_valid;
  logic [H+2:0]     fr_hue6;
  logic [F:0]       fr_sat, fr_lvl, fr_c;
  logic [F+1:0]     fr_v;

  logic             dv_valid;
  logic [F:0]       dv_quot;
  logic [F+1:0]     dv_den;
  logic [SIDE_W-1:0] dv_side;

  color_model_e     sd_model;
  logic [H+2:0]     sd_hue6;
  logic [F:0]       sd_sat, sd_lvl;

  logic             sel_vld_q;
  logic [H+2:0]     sel_hue6_q;
  logic [F:0]       sel_sat_q, sel_lvl_q;
  logic [F:0]       ratio, v_sat;
  logic [2:0]       ch_vld_q;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= MODEL_HSV;
    end else if (cfg_valid_i) begin
      model_q <= color_model_e'(cfg_data_i);
    end
  end

  hsc_front #(.FRAC_BITS(F), .HUE_BITS(H)) u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .hue_i(hue_turn_i), .sat_i(sat_in_i), .level_i(level_in_i),
    .valid_o(fr_valid), .hue6_o(fr_hue6), .sat_o(fr_sat), .level_o(fr_lvl),
    .chroma_o(fr_c), .val_o(fr_v)
  );

  hsc_div #(.FRAC_BITS(F), .SIDE_W(SIDE_W)) u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(fr_valid), .num_i(fr_c), .den_i(fr_v),
    .side_i({model_q, fr_hue6, fr_sat, fr_lvl}),
    .valid_o(dv_valid), .quot_o(dv_quot), .den_o(dv_den), .side_o(dv_side)
  );

  assign sd_model = color_model_e'(dv_side[SIDE_W-1]);
  assign sd_hue6  = dv_side[SIDE_W-2 -: H+3];
  assign sd_sat   = dv_side[2*F+1:F+1];
  assign sd_lvl   = dv_side[F:0];

  // zero value or a ratio above one gives zero saturation
  assign ratio = ((dv_den == '0) || (dv_quot > ONE)) ? '0 : dv_quot;
  assign v_sat = (dv_den > (F+2)'(ONE)) ? ONE : dv_den[F:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_vld_q <= 1'b0;
      ch_vld_q  <= '0;
    end else if (en) begin
      sel_vld_q <= dv_valid;
      ch_vld_q  <= {ch_vld_q[1:0], sel_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel_hue6_q <= sd_hue6;
      sel_sat_q  <= (sd_model == MODEL_HSL) ? ratio : sd_sat;
      sel_lvl_q  <= (sd_model == MODEL_HSL) ? v_sat : sd_lvl;
    end
  end

  hsc_chan #(.FRAC_BITS(F), .HUE_BITS(H), .OFFSET(OFFS_RED)) u_red (
    .clk_i, .en_i(en), .hue6_i(sel_hue6_q), .sat_i(sel_sat_q), .level_i(sel_lvl_q),
    .chan_o(red_out_o)
  );

  hsc_chan #(.FRAC_BITS(F), .HUE_BITS(H), .OFFSET(OFFS_GREEN)) u_green (
    .clk_i, .en_i(en), .hue6_i(sel_hue6_q), .sat_i(sel_sat_q), .level_i(sel_lvl_q),
    .chan_o(green_out_o)
  );

  hsc_chan #(.FRAC_BITS(F), .HUE_BITS(H), .OFFSET(OFFS_BLUE)) u_blue (
    .clk_i, .en_i(en), .hue6_i(sel_hue6_q), .sat_i(sel_sat_q), .level_i(sel_lvl_q),
    .chan_o(blue_out_o)
  );

  assign out_valid_o = ch_vld_q[2];

endmodule

[src/hsc_checker.sv]
// port-level checks for the converter, bound to the top level
module hsc_checker #(
  parameter int unsigned FRAC_BITS = 12
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [FRAC_BITS:0]   red_out_o,
  input logic [FRAC_BITS:0]   green_out_o,
  input logic [FRAC_BITS:0]   blue_out_o
);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(red_out_o) && $stable(green_out_o)
      && $stable(blue_out_o))
    else $error("output payload changed while stalled");

  // an empty output register never blocks the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> red_out_o <= ONE && green_out_o <= ONE && blue_out_o <= ONE)
    else $error("channel above one");

endmodule

bind hsv_hsl_to_rgb_converter_unit hsc_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_hsc_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i,
  .red_out_o, .green_out_o, .blue_out_o
);
